>>> rtl/core/brod_pkg.sv
// Shared types, codes and defaults for the broadcast ring with overrun detection.
// Used by every module under rtl/core; depends on nothing else.
package brod_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_CHANNELS   = 4;
    localparam int DEF_SLOTS      = 16;
    localparam int DEF_READERS    = 8;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths.
    localparam int FUNC_W       = 2;
    localparam int CHANNEL_W    = 2;
    localparam int READER_ID_W  = 3;
    localparam int LEN_W        = 20;
    localparam int SIDE_W       = 32;
    localparam int TYPE_W       = 8;
    localparam int SLOT_INDEX_W = 4;
    localparam int STATUS_W     = 3;
    localparam int CFG_SLOTS_W  = 5;
    localparam int CFG_CHANS_W  = 3;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    // Configuration register reset values.
    localparam logic [CFG_SLOTS_W-1:0] RST_SLOTS_IN_USE    = 5'd16;
    localparam logic [CFG_CHANS_W-1:0] RST_CHANNELS_IN_USE = 3'd4;
    localparam logic [LEN_W-1:0]       RST_MAX_NODE_BYTES  = 20'd524288;
    localparam logic [TYPE_W-1:0]      RST_DATA_TYPE       = 8'd0;

    // Register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_SLOTS_IN_USE    = 2'd0;
    localparam logic [1:0] REG_CHANNELS_IN_USE = 2'd1;
    localparam logic [1:0] REG_MAX_NODE_BYTES  = 2'd2;
    localparam logic [1:0] REG_DATA_TYPE       = 2'd3;

    // Command codes on the func port.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_LOST        = 3'd2,
        ST_BAD_CHANNEL = 3'd3,
        ST_NOT_OPEN    = 3'd4
    } status_t;

    // Operation after classification by the front end.
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_OPEN,
        OP_CLOSE,
        OP_BAD_CHANNEL,
        OP_BAD_READER
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [CHANNEL_W-1:0]   channel;
        logic [READER_ID_W-1:0] reader_id;
    } cmd_t;

    typedef struct packed {
        logic [CFG_SLOTS_W-1:0] slots_in_use;
        logic [CFG_CHANS_W-1:0] channels_in_use;
        logic [LEN_W-1:0]       max_node_bytes;
        logic [TYPE_W-1:0]      data_type;
    } cfg_t;

endpackage

>>> rtl/core/brod_regs.sv
// Configuration register file with its APB-style access port.
// Depends on brod_pkg for the register layout and reset values.
module brod_regs
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [brod_pkg::PADDR_W-1:0] paddr,
    input  logic [brod_pkg::PDATA_W-1:0] pwdata,
    output logic [brod_pkg::PDATA_W-1:0] prdata,
    output logic                     pready,
    output brod_pkg::cfg_t           cfg
);
    import brod_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SLOTS_IN_USE:    cfg_next.slots_in_use    = pwdata[CFG_SLOTS_W-1:0];
                REG_CHANNELS_IN_USE: cfg_next.channels_in_use = pwdata[CFG_CHANS_W-1:0];
                REG_MAX_NODE_BYTES:  cfg_next.max_node_bytes  = pwdata[LEN_W-1:0];
                REG_DATA_TYPE:       cfg_next.data_type       = pwdata[TYPE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SLOTS_IN_USE:    prdata = PDATA_W'(cfg_reg.slots_in_use);
            REG_CHANNELS_IN_USE: prdata = PDATA_W'(cfg_reg.channels_in_use);
            REG_MAX_NODE_BYTES:  prdata = PDATA_W'(cfg_reg.max_node_bytes);
            REG_DATA_TYPE:       prdata = PDATA_W'(cfg_reg.data_type);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slots_in_use    <= RST_SLOTS_IN_USE;
            cfg_reg.channels_in_use <= RST_CHANNELS_IN_USE;
            cfg_reg.max_node_bytes  <= RST_MAX_NODE_BYTES;
            cfg_reg.data_type       <= RST_DATA_TYPE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/brod_front.sv
// Front end: takes command beats and classifies them against the configuration.
// Depends on brod_pkg for the command codes and the classified command type.
module brod_front #(
    parameter int CHANNELS = brod_pkg::DEF_CHANNELS,
    parameter int READERS  = brod_pkg::DEF_READERS
)
(
    input  logic                             start,
    input  logic [brod_pkg::FUNC_W-1:0]      func,
    input  logic [brod_pkg::CHANNEL_W-1:0]   channel,
    input  logic [brod_pkg::READER_ID_W-1:0] reader_id,
    input  brod_pkg::cfg_t                   cfg,
    input  logic                             queue_full,
    output logic                             busy,
    output logic                             push,
    output brod_pkg::cmd_t                   cmd
);
    import brod_pkg::*;

    localparam int CMP_W = 7;
    localparam logic [CMP_W-1:0] CHAN_MAX    = CMP_W'(CHANNELS);
    localparam logic [CMP_W-1:0] READER_LIM  = CMP_W'(READERS);

    logic [CMP_W-1:0] chan_cfg;
    logic [CMP_W-1:0] chan_limit;
    logic             chan_bad;
    logic             reader_bad;

    assign busy = queue_full;
    assign push = start & ~queue_full;

    assign chan_cfg   = CMP_W'(cfg.channels_in_use);
    assign chan_limit = (chan_cfg > CHAN_MAX) ? CHAN_MAX : chan_cfg;
    assign chan_bad   = CMP_W'(channel) >= chan_limit;
    assign reader_bad = CMP_W'(reader_id) >= READER_LIM;

    always_comb
    begin
        cmd.channel   = channel;
        cmd.reader_id = reader_id;
        if ((func == FUNC_WRITE || func == FUNC_OPEN) && chan_bad)
        begin
            cmd.op = OP_BAD_CHANNEL;
        end
        else if (func != FUNC_WRITE && reader_bad)
        begin
            cmd.op = OP_BAD_READER;
        end
        else
        begin
            case (func)
                FUNC_WRITE: cmd.op = OP_WRITE;
                FUNC_READ:  cmd.op = OP_READ;
                FUNC_OPEN:  cmd.op = OP_OPEN;
                FUNC_CLOSE: cmd.op = OP_CLOSE;
                default:    cmd.op = OP_BAD_READER;
            endcase
        end
    end

endmodule

>>> rtl/core/brod_fifo.sv
// Short command queue between the front end and the back end.
// Depends on brod_pkg only for the shared import convention.
module brod_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);
    import brod_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_DEPTH);
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/brod_back.sv
// Back end: ring positions, reader table, slot store and the result register.
// Depends on brod_pkg for the command, status and configuration types.
module brod_back #(
    parameter int CHANNELS   = brod_pkg::DEF_CHANNELS,
    parameter int SLOTS      = brod_pkg::DEF_SLOTS,
    parameter int READERS    = brod_pkg::DEF_READERS,
    parameter int DATA_WIDTH = brod_pkg::DEF_DATA_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  brod_pkg::cfg_t                    cfg,
    input  logic                              cmd_valid,
    input  brod_pkg::cmd_t                    cmd,
    input  logic [DATA_WIDTH-1:0]             cmd_payload,
    input  logic [brod_pkg::LEN_W-1:0]        cmd_len,
    input  logic [brod_pkg::SIDE_W-1:0]       cmd_side,
    output logic                              cmd_pop,
    output logic                              done,
    output logic [brod_pkg::STATUS_W-1:0]     status,
    output logic [DATA_WIDTH-1:0]             data,
    output logic [brod_pkg::LEN_W-1:0]        length,
    output logic [brod_pkg::SIDE_W-1:0]       side_info_out,
    output logic [brod_pkg::TYPE_W-1:0]       type_out,
    output logic [brod_pkg::SLOT_INDEX_W-1:0] slot_index
);
    import brod_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SL_W    = $clog2(SLOTS);
    localparam int RD_W    = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int ADDR_W  = CH_W + SL_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int RING_A  = $clog2(SLOTS + 1);
    localparam int RING_W  = (RING_A > CFG_SLOTS_W) ? RING_A : CFG_SLOTS_W;
    localparam int ENTRY_W = TYPE_W + SIDE_W + LEN_W + DATA_WIDTH;
    localparam logic [RING_W-1:0] RING_MIN = RING_W'(2);
    localparam logic [RING_W-1:0] RING_MAX = RING_W'(SLOTS);

    // Ring positions and reader table.
    logic [SL_W-1:0] write_position_reg  [CHANNELS];
    logic [SL_W-1:0] write_position_next [CHANNELS];
    logic            reader_open_reg     [READERS];
    logic            reader_open_next    [READERS];
    logic [CH_W-1:0] reader_channel_reg  [READERS];
    logic [CH_W-1:0] reader_channel_next [READERS];
    logic [SL_W-1:0] reader_begin_reg    [READERS];
    logic [SL_W-1:0] reader_begin_next   [READERS];
    logic [SL_W-1:0] reader_end_reg      [READERS];
    logic [SL_W-1:0] reader_end_next     [READERS];

    // Slot store: one word per slot of every channel.
    logic [ENTRY_W-1:0] slot_store_reg [DEPTH];
    logic [ENTRY_W-1:0] slot_q_reg;

    // Result register.
    logic                    done_reg;
    logic                    done_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic [SLOT_INDEX_W-1:0] slot_index_reg;
    logic [SLOT_INDEX_W-1:0] slot_index_next;
    logic                    read_ok_reg;
    logic                    read_ok_next;

    logic [RING_W-1:0] slots_ext;
    logic [RING_W-1:0] ring_len;
    logic [CH_W-1:0]   cmd_ch;
    logic [RD_W-1:0]   rid;
    logic [CH_W-1:0]   rd_ch;
    logic [CH_W-1:0]   pos_ch;
    logic [SL_W-1:0]   wp;
    logic [SL_W-1:0]   rb;
    logic [SL_W-1:0]   re;
    logic              in_order;
    logic [LEN_W-1:0]  sat_len;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [SL_W-1:0]   mem_pos;
    logic [ENTRY_W-1:0] mem_wdata;

    function automatic logic [SL_W-1:0] advance(input logic [SL_W-1:0] p,
                                                input logic [RING_W-1:0] ring);
        logic [RING_W-1:0] nxt;
        nxt = RING_W'(p) + RING_W'(1);
        return (nxt >= ring) ? '0 : SL_W'(nxt);
    endfunction

    assign cmd_pop = cmd_valid;

    assign slots_ext = RING_W'(cfg.slots_in_use);
    assign ring_len  = (slots_ext < RING_MIN) ? RING_MIN :
                       (slots_ext > RING_MAX) ? RING_MAX : slots_ext;

    assign cmd_ch = CH_W'(cmd.channel);
    assign rid    = RD_W'(cmd.reader_id);
    assign rd_ch  = reader_channel_reg[rid];
    assign pos_ch = (cmd.op == OP_READ) ? rd_ch : cmd_ch;
    assign wp     = write_position_reg[pos_ch];
    assign rb     = reader_begin_reg[rid];
    assign re     = reader_end_reg[rid];

    // Begin, end and write position still in cyclic order: nothing overrun.
    assign in_order = ((rb <= re) && (re <= wp)) || ((re <= wp) && (wp <= rb)) ||
                      ((wp <= rb) && (rb <= re));

    assign sat_len   = (cmd_len > cfg.max_node_bytes) ? cfg.max_node_bytes : cmd_len;
    assign mem_wdata = {cfg.data_type, cmd_side, sat_len, cmd_payload};
    assign mem_pos   = (cmd.op == OP_WRITE) ? wp : rb;
    assign mem_addr  = {pos_ch, mem_pos};
    assign mem_we    = cmd_valid && (cmd.op == OP_WRITE);
    assign mem_re    = cmd_valid && (cmd.op == OP_READ);

    always_comb
    begin
        write_position_next = write_position_reg;
        reader_open_next    = reader_open_reg;
        reader_channel_next = reader_channel_reg;
        reader_begin_next   = reader_begin_reg;
        reader_end_next     = reader_end_reg;
        done_next           = cmd_valid;
        status_next         = ST_OK;
        slot_index_next     = '0;
        read_ok_next        = 1'b0;
        if (cmd_valid)
        begin
            case (cmd.op)
                OP_WRITE:
                begin
                    write_position_next[pos_ch] = advance(wp, ring_len);
                    slot_index_next             = SLOT_INDEX_W'(wp);
                end
                OP_OPEN:
                begin
                    reader_open_next[rid]    = 1'b1;
                    reader_channel_next[rid] = cmd_ch;
                    reader_begin_next[rid]   = wp;
                    reader_end_next[rid]     = wp;
                    slot_index_next          = SLOT_INDEX_W'(wp);
                end
                OP_CLOSE:
                begin
                    if (reader_open_reg[rid])
                    begin
                        reader_open_next[rid] = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_NOT_OPEN;
                    end
                end
                OP_READ:
                begin
                    if (!reader_open_reg[rid])
                    begin
                        status_next = ST_NOT_OPEN;
                    end
                    else if (rb == re && re == wp)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (in_order)
                    begin
                        reader_end_next[rid]   = wp;
                        reader_begin_next[rid] = advance(rb, ring_len);
                        slot_index_next        = SLOT_INDEX_W'(rb);
                        read_ok_next           = 1'b1;
                    end
                    else
                    begin
                        // Writer lapped the reader: resync to the write position.
                        reader_end_next[rid]   = wp;
                        reader_begin_next[rid] = wp;
                        status_next            = ST_LOST;
                        slot_index_next        = SLOT_INDEX_W'(wp);
                    end
                end
                OP_BAD_CHANNEL: status_next = ST_BAD_CHANNEL;
                OP_BAD_READER:  status_next = ST_NOT_OPEN;
                default:        status_next = ST_NOT_OPEN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                write_position_reg[i] <= '0;
            end
            for (int i = 0; i < READERS; i++)
            begin
                reader_open_reg[i]    <= 1'b0;
                reader_channel_reg[i] <= '0;
                reader_begin_reg[i]   <= '0;
                reader_end_reg[i]     <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            write_position_reg <= write_position_next;
            reader_open_reg    <= reader_open_next;
            reader_channel_reg <= reader_channel_next;
            reader_begin_reg   <= reader_begin_next;
            reader_end_reg     <= reader_end_next;
            done_reg           <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        slot_index_reg <= slot_index_next;
        read_ok_reg    <= read_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_store_reg[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            slot_q_reg <= slot_store_reg[mem_addr];
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot_index    = slot_index_reg;
    assign data          = read_ok_reg ? slot_q_reg[DATA_WIDTH-1:0] : '0;
    assign length        = read_ok_reg ? slot_q_reg[DATA_WIDTH +: LEN_W] : '0;
    assign side_info_out = read_ok_reg ? slot_q_reg[DATA_WIDTH+LEN_W +: SIDE_W] : '0;
    assign type_out      = read_ok_reg ? slot_q_reg[DATA_WIDTH+LEN_W+SIDE_W +: TYPE_W] : '0;

endmodule

>>> rtl/core/broadcast_ring_with_overrun_detect_unit.sv
// Top level of the broadcast ring with overrun detection.
// Depends on brod_pkg, brod_regs, brod_front, brod_fifo and brod_back.
//
//   Channel   | Handshake                    | Beat contents
//   ----------+------------------------------+-----------------------------------------
//   command   | start, busy                  | func, channel, reader_id, payload,
//             |                              | total_len, side_info
//   result    | done (one-cycle strobe)      | status, data, length, side_info_out,
//             |                              | type_out, slot_index
//   config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A command beat is taken at an edge with start high and busy low. Its result passes
// through the command queue and then the back end's result register, beside which the
// slot store read is registered. The back end retires one command per cycle, so a
// new command can be taken every cycle. busy rises only when the two-entry queue fills.
// Reset clears the ring positions and the reader table; the slot store is not cleared.
// Results cannot be held off by the receiver.
module broadcast_ring_with_overrun_detect_unit #(
    parameter int CHANNELS   = brod_pkg::DEF_CHANNELS,
    parameter int SLOTS      = brod_pkg::DEF_SLOTS,
    parameter int READERS    = brod_pkg::DEF_READERS,
    parameter int DATA_WIDTH = brod_pkg::DEF_DATA_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [brod_pkg::FUNC_W-1:0]       func,
    input  logic [brod_pkg::CHANNEL_W-1:0]    channel,
    input  logic [brod_pkg::READER_ID_W-1:0]  reader_id,
    input  logic [DATA_WIDTH-1:0]             payload,
    input  logic [brod_pkg::LEN_W-1:0]        total_len,
    input  logic [brod_pkg::SIDE_W-1:0]       side_info,
    output logic                              done,
    output logic [brod_pkg::STATUS_W-1:0]     status,
    output logic [DATA_WIDTH-1:0]             data,
    output logic [brod_pkg::LEN_W-1:0]        length,
    output logic [brod_pkg::SIDE_W-1:0]       side_info_out,
    output logic [brod_pkg::TYPE_W-1:0]       type_out,
    output logic [brod_pkg::SLOT_INDEX_W-1:0] slot_index,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brod_pkg::PADDR_W-1:0]      paddr,
    input  logic [brod_pkg::PDATA_W-1:0]      pwdata,
    output logic [brod_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import brod_pkg::*;

    localparam int Q_WIDTH = $bits(cmd_t) + DATA_WIDTH + LEN_W + SIDE_W;
    localparam int Q_DEPTH = 2;

    cfg_t                 cfg;
    cmd_t                 front_cmd;
    cmd_t                 back_cmd;
    logic                 push;
    logic                 queue_full;
    logic                 queue_not_empty;
    logic                 pop;
    logic [Q_WIDTH-1:0]   q_in;
    logic [Q_WIDTH-1:0]   q_out;
    logic [DATA_WIDTH-1:0] q_payload;
    logic [LEN_W-1:0]     q_len;
    logic [SIDE_W-1:0]    q_side;

    brod_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brod_front #(
        .CHANNELS (CHANNELS),
        .READERS  (READERS)
    ) u_front (
        .start      (start),
        .func       (func),
        .channel    (channel),
        .reader_id  (reader_id),
        .cfg        (cfg),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .cmd        (front_cmd)
    );

    assign q_in = {front_cmd, payload, total_len, side_info};

    brod_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    assign {back_cmd, q_payload, q_len, q_side} = q_out;

    brod_back #(
        .CHANNELS   (CHANNELS),
        .SLOTS      (SLOTS),
        .READERS    (READERS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd_valid     (queue_not_empty),
        .cmd           (back_cmd),
        .cmd_payload   (q_payload),
        .cmd_len       (q_len),
        .cmd_side      (q_side),
        .cmd_pop       (pop),
        .done          (done),
        .status        (status),
        .data          (data),
        .length        (length),
        .side_info_out (side_info_out),
        .type_out      (type_out),
        .slot_index    (slot_index)
    );

endmodule
